/* rtl/core/mbc1_pkg.sv */
// Shared constants, request codes and the queue item type of the bank controller.
`default_nettype none
package mbc1_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int MAX_ROM_BANKS_DEF = 128;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int ROM_ADDR_W = 21;
  localparam int RAM_ADDR_W = 15;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] OPEN_BUS = 8'hFF;
  localparam logic [7:0] RAM_EN_KEY = 8'h0A;
  localparam logic [4:0] LOW_BANK_FIX = 5'b00001;

  localparam logic [1:0] REQ_READ = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  localparam logic [1:0] CFG_ROM_BANKS = 2'd0;
  localparam logic [1:0] CFG_BANK_MASK = 2'd1;
  localparam logic [1:0] CFG_RAM_BYTES = 2'd2;

  // Address regions by the top three address bits.
  localparam logic [2:0] REGION_RAM_EN = 3'b000;
  localparam logic [2:0] REGION_LOW_BANK = 3'b001;
  localparam logic [2:0] REGION_HIGH_BANK = 3'b010;
  localparam logic [2:0] REGION_MODE = 3'b011;
  localparam logic [2:0] REGION_RAM = 3'b101;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ROM_RD = 3'd1,
    OP_RAM_RD = 3'd2,
    OP_ROM_WR = 3'd3,
    OP_RAM_WR = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [ROM_ADDR_W-1:0]   rom_addr;
    logic [RAM_ADDR_W-1:0]   ram_addr;
    logic [7:0]              data;
  } mem_op_t;

endpackage
`default_nettype wire

/* rtl/core/mbc1_front.sv */
// Front end: accepts items, keeps the bank registers and turns items into memory operations.
`default_nettype none
module mbc1_front
  import mbc1_pkg::*;
#(
  parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [47:0]           s_axis_tdata,
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_full,
  output logic                       q_push,
  output mem_op_t                    q_item
);

  localparam int LIM_W = ROM_ADDR_W + 1;
  localparam logic [LIM_W-1:0] ROM_LIMIT = LIM_W'(MAX_ROM_BANKS * ROM_BANK_BYTES);
  localparam logic [7:0] ROM_BANK_LIMIT = 8'(MAX_ROM_BANKS);

  logic [7:0]  rom_banks;
  logic [4:0]  bank_mask;
  logic [15:0] ram_bytes;
  logic        ram_enabled;
  logic        bank_mode;
  logic [4:0]  low_rom_bank;
  logic [1:0]  high_bank;

  logic [1:0]            req_type;
  logic [15:0]           bus_address;
  logic [7:0]            bus_data;
  logic [ROM_ADDR_W-1:0] rom_load_address;
  logic [2:0]            region;
  logic [6:0]            hb_shift;
  logic [6:0]            bank_lo;
  logic [6:0]            bank_hi_raw;
  logic [6:0]            bank_hi;
  logic [6:0]            rom_bank;
  logic                  rom_ok;
  logic                  ram_ok;
  logic [1:0]            ram_bank;
  logic [4:0]            low_fixed;

  assign req_type         = s_axis_tuser;
  assign bus_address      = s_axis_tdata[15:0];
  assign bus_data         = s_axis_tdata[23:16];
  assign rom_load_address = s_axis_tdata[44:24];
  assign region           = bus_address[15:13];

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_comb begin
    hb_shift    = {high_bank, 5'b00000};
    bank_lo     = (bank_mode && ({1'b0, hb_shift} < rom_banks)) ? hb_shift : 7'd0;
    bank_hi_raw = {high_bank, low_rom_bank};
    bank_hi     = ({1'b0, bank_hi_raw} < rom_banks) ? bank_hi_raw : {2'b00, low_rom_bank};
    rom_bank    = bus_address[14] ? bank_hi : bank_lo;
    rom_ok      = {1'b0, rom_bank} < ROM_BANK_LIMIT;
    ram_ok      = ram_enabled && (region == REGION_RAM) &&
                  ({3'b000, bus_address[12:0]} < ram_bytes);
    ram_bank    = bank_mode ? high_bank : 2'b00;
    low_fixed   = (bus_data[4:0] == 5'd0) ? LOW_BANK_FIX : bus_data[4:0];

    q_item.kind     = OP_NONE;
    q_item.rom_addr = {rom_bank, bus_address[13:0]};
    q_item.ram_addr = {ram_bank, bus_address[12:0]};
    q_item.data     = bus_data;
    case (req_type)
      REQ_READ: begin
        if (!bus_address[15]) begin
          if (rom_ok) q_item.kind = OP_ROM_RD;
        end else if (ram_ok) begin
          q_item.kind = OP_RAM_RD;
        end
      end
      REQ_WRITE: begin
        if (ram_ok) q_item.kind = OP_RAM_WR;
      end
      REQ_LOAD: begin
        q_item.rom_addr = rom_load_address;
        if ({1'b0, rom_load_address} < ROM_LIMIT) q_item.kind = OP_ROM_WR;
      end
      default: q_item.kind = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled  <= 1'b0;
      bank_mode    <= 1'b0;
      low_rom_bank <= 5'd0;
      high_bank    <= 2'd0;
    end else if (q_push && (req_type == REQ_WRITE)) begin
      case (region)
        REGION_RAM_EN:    ram_enabled  <= (bus_data == RAM_EN_KEY);
        REGION_LOW_BANK:  low_rom_bank <= bank_mask & low_fixed;
        REGION_HIGH_BANK: high_bank    <= bus_data[1:0];
        REGION_MODE:      bank_mode    <= bus_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_banks <= 8'd2;
      bank_mask <= 5'd31;
      ram_bytes <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROM_BANKS: rom_banks <= cfg_data[7:0];
        CFG_BANK_MASK: bank_mask <= cfg_data[4:0];
        CFG_RAM_BYTES: ram_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mbc1_queue.sv */
// Short first-in first-out queue of memory operations between front and back.
`default_nettype none
module mbc1_queue
  import mbc1_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire mem_op_t push_item,
  input  wire logic    pop,
  output mem_op_t      head_item,
  output logic         full,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  mem_op_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mbc1_back.sv */
// Back end: ROM and RAM arrays, registered reads and the output register.
`default_nettype none
module mbc1_back
  import mbc1_pkg::*;
#(
  parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mem_op_t     head_item,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata
);

  localparam int ROM_DEPTH = MAX_ROM_BANKS * ROM_BANK_BYTES;
  localparam int ROM_AW = $clog2(ROM_DEPTH);
  localparam int RAM_DEPTH = 1 << RAM_ADDR_W;

  logic [7:0] rom_mem [ROM_DEPTH];
  logic [7:0] ram_mem [RAM_DEPTH];

  logic       s1_valid;
  op_kind_t   s1_kind;
  logic [7:0] rom_q;
  logic [7:0] ram_q;
  logic       s1_adv;
  logic [7:0] s1_data;

  assign s1_adv = !m_axis_tvalid || m_axis_tready;
  assign q_pop  = !q_empty && (!s1_valid || s1_adv);

  always_comb begin
    case (s1_kind)
      OP_ROM_RD: s1_data = rom_q;
      OP_RAM_RD: s1_data = ram_q;
      default:   s1_data = OPEN_BUS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && (head_item.kind == OP_ROM_WR)) begin
      rom_mem[head_item.rom_addr[ROM_AW-1:0]] <= head_item.data;
    end
    if (q_pop && (head_item.kind == OP_ROM_RD)) begin
      rom_q <= rom_mem[head_item.rom_addr[ROM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (head_item.kind == OP_RAM_WR)) begin
      ram_mem[head_item.ram_addr] <= head_item.data;
    end
    if (q_pop && (head_item.kind == OP_RAM_RD)) begin
      ram_q <= ram_mem[head_item.ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) s1_kind <= head_item.kind;
    if (s1_adv) m_axis_tdata <= s1_data;
  end

endmodule
`default_nettype wire

/* rtl/core/mbc1_bank_controller.sv */
// Top level of the cartridge bank controller.
// Throughput: one item per cycle unless the output stalls; the single-port ROM and RAM
// arrays take one access a cycle. An item passes the queue, array read and output register.
// Reset clears the bank registers, the queue and the output, and sets the configuration
// registers to their defaults; ROM and RAM contents are not cleared and no sweep is needed.
`default_nettype none
module mbc1_bank_controller
  import mbc1_pkg::*;
#(
  parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // bus_address[15:0], bus_data[23:16], rom_load_address[44:24], zero fill.
  input  wire logic [47:0]           s_axis_tdata,
  // req_type[1:0].
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // read_data[7:0].
  output logic [7:0]                 m_axis_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  mem_op_t push_item;
  mem_op_t head_item;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;

  mbc1_front #(
    .MAX_ROM_BANKS(MAX_ROM_BANKS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  mbc1_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  mbc1_back #(
    .MAX_ROM_BANKS(MAX_ROM_BANKS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_item     (head_item),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> (q_empty && !m_axis_tvalid))
    else $error("Queue or output not cleared after reset.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("Item taken from an empty queue.");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_empty) |=> !q_empty)
    else $error("Item pushed into an empty queue was lost.");

endmodule
`default_nettype wire
